[design/hsrm_pkg.sv]
package hsrm_pkg;

  // Key geometry
  localparam int unsigned KEY_DIGITS     = 35;
  localparam int unsigned KEY_DIGITS_MAX = 35;
  localparam int unsigned KEY_BITS       = 4 * KEY_DIGITS_MAX;
  localparam int unsigned KEY_POS_W      = 6;
  localparam int unsigned COUNT_W        = 31;

  localparam logic [KEY_POS_W-1:0] KEY_POS_MAX = '1;
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;

  // Configuration register indexes
  localparam int unsigned            CFG_IDX_W     = 2;
  localparam logic [CFG_IDX_W-1:0]   CFG_KEY_UPPER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]   CFG_KEY_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0]   CFG_KEY_LOWER  = 2'd2;
  localparam int unsigned            CFG_DATA_W     = 64;
  localparam int unsigned            KEY_LOWER_W    = 12;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic               closing;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

[design/hsrm_key_match.sv]
module hsrm_key_match #(
  parameter int unsigned KeyDigits = hsrm_pkg::KEY_DIGITS
) (
  input  logic [7:0]                     data_byte_i,
  input  logic [hsrm_pkg::KEY_POS_W-1:0] key_pos_i,
  input  logic [hsrm_pkg::KEY_BITS-1:0]  key_i,
  output logic                           mismatch_o
);

  logic [3:0] key_nib [hsrm_pkg::KEY_DIGITS_MAX];
  logic [3:0] sel_nib;
  logic [3:0] hex_val;
  logic       hex_ok;
  logic       pos_out;

  for (genvar g = 0; g < hsrm_pkg::KEY_DIGITS_MAX; g++) begin : g_nib
    assign key_nib[g] = key_i[hsrm_pkg::KEY_BITS-1-4*g -: 4];
  end

  // Case-insensitive hex decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      hex_val = data_byte_i[3:0];
    end else if ((data_byte_i >= 8'h41 && data_byte_i <= 8'h46) ||
                 (data_byte_i >= 8'h61 && data_byte_i <= 8'h66)) begin
      hex_val = data_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign pos_out = key_pos_i >= hsrm_pkg::KEY_POS_W'(KeyDigits);
  assign sel_nib = (key_pos_i < hsrm_pkg::KEY_POS_W'(hsrm_pkg::KEY_DIGITS_MAX)) ?
                   key_nib[key_pos_i] : 4'd0;

  assign mismatch_o = pos_out || !hex_ok || (hex_val != sel_nib);

endmodule

[design/hsrm_scan.sv]
module hsrm_scan #(
  parameter int unsigned KeyDigits = hsrm_pkg::KEY_DIGITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  hsrm_pkg::item_t               item_i,
  input  logic [hsrm_pkg::KEY_BITS-1:0] key_i,
  output hsrm_pkg::result_t             res_o
);

  typedef enum logic [2:0] {
    PH_KEY,
    PH_SPACE,
    PH_SIGNED,
    PH_DIGITS,
    PH_DONE,
    PH_SKIP
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [hsrm_pkg::KEY_POS_W-1:0]  pos_q, pos_d;
  logic                            mism_q, mism_d;
  logic                            neg_q, neg_d;
  logic                            dig_q, dig_d;
  logic [hsrm_pkg::COUNT_W-1:0]    acc_q, acc_d;
  logic                            ovf_q, ovf_d;

  logic [7:0]                      c;
  logic                            closing;
  logic                            is_digit;
  logic                            is_blank;
  logic                            nib_mism;
  logic [hsrm_pkg::COUNT_W+3:0]    acc_ext;
  logic [hsrm_pkg::COUNT_W+3:0]    acc_new;
  logic                            matched;

  assign c        = item_i.data_byte;
  assign closing  = item_i.last || (c == hsrm_pkg::CH_NUL);
  assign is_digit = (c >= hsrm_pkg::CH_ZERO) && (c <= hsrm_pkg::CH_NINE);
  assign is_blank = (c == hsrm_pkg::CH_SPACE) || (c == hsrm_pkg::CH_TAB) ||
                    (c == hsrm_pkg::CH_VT) || (c == hsrm_pkg::CH_FF);

  hsrm_key_match #(
    .KeyDigits(KeyDigits)
  ) u_key_match (
    .data_byte_i(c),
    .key_pos_i  (pos_q),
    .key_i      (key_i),
    .mismatch_o (nib_mism)
  );

  // acc * 10 + digit, wide enough to see the overflow
  assign acc_ext = {4'b0, acc_q};
  assign acc_new = (acc_ext << 3) + (acc_ext << 1) +
                   {{(hsrm_pkg::COUNT_W){1'b0}}, c[3:0]};

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    mism_d  = mism_q;
    neg_d   = neg_q;
    dig_d   = dig_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    matched = 1'b0;
    res_o.closing = closing;
    res_o.count   = '0;

    if (c != hsrm_pkg::CH_NUL) begin
      unique case (phase_q)
        PH_KEY: begin
          if (c == hsrm_pkg::CH_LF) begin
            pos_d  = '0;
            mism_d = 1'b0;
          end else if (c == hsrm_pkg::CH_CR) begin
            phase_d = PH_SKIP;
          end else if (c == hsrm_pkg::CH_COLON) begin
            if (!mism_q && pos_q == hsrm_pkg::KEY_POS_W'(KeyDigits)) begin
              phase_d = PH_SPACE;
            end else begin
              phase_d = PH_SKIP;
            end
          end else begin
            if (nib_mism) begin
              mism_d = 1'b1;
            end
            if (pos_q != hsrm_pkg::KEY_POS_MAX) begin
              pos_d = pos_q + 1'b1;
            end
          end
        end
        PH_SPACE, PH_SIGNED, PH_DIGITS: begin
          if (phase_q == PH_SPACE && is_blank) begin
            phase_d = PH_SPACE;
          end else if (phase_q == PH_SPACE && c == hsrm_pkg::CH_PLUS) begin
            phase_d = PH_SIGNED;
          end else if (phase_q == PH_SPACE && c == hsrm_pkg::CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGNED;
          end else if (is_digit) begin
            dig_d   = 1'b1;
            phase_d = PH_DIGITS;
            if (!ovf_q) begin
              if (acc_new > (hsrm_pkg::COUNT_W+4)'(hsrm_pkg::COUNT_MAX)) begin
                ovf_d = 1'b1;
                acc_d = hsrm_pkg::COUNT_MAX;
              end else begin
                acc_d = acc_new[hsrm_pkg::COUNT_W-1:0];
              end
            end
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_SKIP: begin
          if (c == hsrm_pkg::CH_LF) begin
            phase_d = PH_KEY;
            pos_d   = '0;
            mism_d  = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (closing) begin
      matched = (phase_d == PH_SPACE) || (phase_d == PH_SIGNED) ||
                (phase_d == PH_DIGITS) || (phase_d == PH_DONE);
      if (matched && dig_d && !neg_d && !ovf_d) begin
        res_o.count = acc_d;
      end
      // fresh response from the next word on
      phase_d = PH_KEY;
      pos_d   = '0;
      mism_d  = 1'b0;
      neg_d   = 1'b0;
      dig_d   = 1'b0;
      acc_d   = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KEY;
      pos_q   <= '0;
      mism_q  <= 1'b0;
      neg_q   <= 1'b0;
      dig_q   <= 1'b0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      mism_q  <= mism_d;
      neg_q   <= neg_d;
      dig_q   <= dig_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

[design/hash_suffix_record_matcher_core.sv]
// Each accepted byte is registered in item_q and scanned from there; a result word is then
// registered in the output register and shown on out_valid_o until it is taken.
// Throughput: one byte per cycle; the output register lets the input run while a result
// waits, and only a closing byte stalls behind an untaken result.
// Reset: rst_ni clears scan state, key registers and both valid flags asynchronously.
module hash_suffix_record_matcher_core #(
  parameter int unsigned KeyDigits = hsrm_pkg::KEY_DIGITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hsrm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hsrm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [hsrm_pkg::COUNT_W-1:0]     breach_count_o
);

  logic [hsrm_pkg::CFG_DATA_W-1:0]  key_upper_q;
  logic [hsrm_pkg::CFG_DATA_W-1:0]  key_middle_q;
  logic [hsrm_pkg::KEY_LOWER_W-1:0] key_lower_q;

  logic                             in_vld_q;
  hsrm_pkg::item_t                  item_q;
  logic                             out_vld_q;
  logic [hsrm_pkg::COUNT_W-1:0]     count_q;

  hsrm_pkg::result_t                res;
  logic                             take;
  logic                             load;

  // A closing byte needs the output register free (or draining this cycle)
  assign take = in_vld_q && (!res.closing || !out_vld_q || !out_stall_i);
  assign load = !in_vld_q || take;

  assign in_stall_o     = !load;
  assign out_valid_o    = out_vld_q;
  assign breach_count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q  <= '0;
      key_middle_q <= '0;
      key_lower_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hsrm_pkg::CFG_KEY_UPPER:  key_upper_q  <= cfg_data_i;
        hsrm_pkg::CFG_KEY_MIDDLE: key_middle_q <= cfg_data_i;
        hsrm_pkg::CFG_KEY_LOWER:  key_lower_q  <= cfg_data_i[hsrm_pkg::KEY_LOWER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (load) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q.data_byte <= data_byte_i;
      item_q.last      <= last_i;
    end
  end

  hsrm_scan #(
    .KeyDigits(KeyDigits)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .item_i(item_q),
    .key_i ({key_upper_q, key_middle_q, key_lower_q}),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take && res.closing) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res.closing) begin
      count_q <= res.count;
    end
  end

endmodule

[design/hsrm_checker.sv]
module hsrm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [hsrm_pkg::COUNT_W-1:0] breach_count_o
);

  // a waiting result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(breach_count_o))
    else $error("stalled result word changed");

  // input back-pressure only comes from a blocked result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  // nothing pending right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("valid or stall set out of reset");

endmodule

bind hash_suffix_record_matcher_core hsrm_checker u_hsrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .breach_count_o(breach_count_o)
);
